[rtl/core/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  // Field widths.
  localparam int HueW   = 9;
  localparam int ChanW  = 8;
  localparam int SectW  = 3;
  localparam int WghtW  = 6;
  localparam int VsW    = 2 * ChanW;
  localparam int ProdW  = VsW + WghtW;

  // Geometry of the hue circle.
  localparam int FullSector = 60;
  localparam int HueMax     = 360;

  // Divisor of the channel drop term, 255 * 60.
  localparam int ScaleDen   = 15300;

  // Reciprocal of the divisor, scaled by 2**RecipShift and rounded down.
  localparam int RecipShift = 32;
  localparam longint RecipM = (64'd1 << RecipShift) / ScaleDen;
  localparam int RecipW     = 19;
  localparam int QuotW      = ProdW + RecipW - RecipShift;

  // Hue sectors.
  typedef enum logic [SectW-1:0] {
    SECT_RED_RISE   = 3'd0,
    SECT_GREEN_FALL = 3'd1,
    SECT_GREEN_RISE = 3'd2,
    SECT_BLUE_FALL  = 3'd3,
    SECT_BLUE_RISE  = 3'd4,
    SECT_RED_FALL   = 3'd5
  } sector_e;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

endpackage

[rtl/core/hsv_to_rgb_color_converter_core.sv]
// HSV to RGB converter, four-stage pipeline.
//
// Input channel: hue_i (0..360 degrees, larger values act as 360), saturation_i and
// brightness_i (255 is full scale), qualified by in_valid_i. A beat is taken at a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: red_o, green_o, blue_o qualified by out_valid_o; the receiver holds
// a beat with out_stall_i, and the beat then stays unchanged on the ports.
//
// out_valid_o rises once a beat has passed all four register stages: sector decode and
// chroma scale, weighted product, reciprocal quotient estimate, and ceiling correction
// with the output register.
// Throughput is one beat per cycle while the receiver does not stall.
//
// A stall freezes only the stages that hold data; empty stages keep filling, so the
// block holds up to four beats while the receiver stalls. in_stall_o rises once all
// stages are full and the receiver still stalls.
// Reset clears every stage valid bit; the block can take a beat as soon as reset ends.
module hsv_to_rgb_color_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  pipe_ctl_t        ctl;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic [VsW-1:0]   vs;
  logic [WghtW-1:0] w_red, w_green, w_blue;
  logic [ChanW-1:0] bright;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ctl.en4 = !v4_q || !out_stall_i;
    ctl.en3 = !v3_q || ctl.en4;
    ctl.en2 = !v2_q || ctl.en3;
    ctl.en1 = !v1_q || ctl.en2;
  end

  assign in_stall_o = !ctl.en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ctl.en1) v1_q <= in_valid_i;
      if (ctl.en2) v2_q <= v1_q;
      if (ctl.en3) v3_q <= v2_q;
      if (ctl.en4) v4_q <= v3_q;
    end
  end

  // Stage one: sector decode and channel weights.
  hsv2rgb_sector u_sector (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .vs_o         (vs),
    .w_red_o      (w_red),
    .w_green_o    (w_green),
    .w_blue_o     (w_blue),
    .bright_o     (bright)
  );

  // Stages two to four, one lane per color.
  hsv2rgb_chan u_chan_red (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .vs_i     (vs),
    .w_i      (w_red),
    .bright_i (bright),
    .level_o  (red_o)
  );

  hsv2rgb_chan u_chan_green (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .vs_i     (vs),
    .w_i      (w_green),
    .bright_i (bright),
    .level_o  (green_o)
  );

  hsv2rgb_chan u_chan_blue (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .vs_i     (vs),
    .w_i      (w_blue),
    .bright_i (bright),
    .level_o  (blue_o)
  );

  assign out_valid_o = v4_q;

endmodule

[rtl/core/hsv2rgb_sector.sv]
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  pipe_ctl_t        ctl_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  output logic [VsW-1:0]   vs_o,
  output logic [WghtW-1:0] w_red_o,
  output logic [WghtW-1:0] w_green_o,
  output logic [WghtW-1:0] w_blue_o,
  output logic [ChanW-1:0] bright_o
);

  sector_e         sector_c;
  logic [HueW-1:0] base_c;
  logic [WghtW-1:0] offset_c;
  logic [WghtW-1:0] ramp_c;
  logic [WghtW-1:0] w_red_d, w_green_d, w_blue_d;
  logic [VsW-1:0]   vs_d;
  logic [VsW-1:0]   vs_q;
  logic [WghtW-1:0] w_red_q, w_green_q, w_blue_q;
  logic [ChanW-1:0] bright_q;

  // Sector search over the five boundaries; 360 and above fold into the last sector.
  always_comb begin
    priority if (hue_i >= HueW'(HueMax)) begin
      sector_c = SECT_RED_FALL;
      base_c   = HueW'(5 * FullSector);
    end else if (hue_i >= HueW'(5 * FullSector)) begin
      sector_c = SECT_RED_FALL;
      base_c   = HueW'(5 * FullSector);
    end else if (hue_i >= HueW'(4 * FullSector)) begin
      sector_c = SECT_BLUE_RISE;
      base_c   = HueW'(4 * FullSector);
    end else if (hue_i >= HueW'(3 * FullSector)) begin
      sector_c = SECT_BLUE_FALL;
      base_c   = HueW'(3 * FullSector);
    end else if (hue_i >= HueW'(2 * FullSector)) begin
      sector_c = SECT_GREEN_RISE;
      base_c   = HueW'(2 * FullSector);
    end else if (hue_i >= HueW'(FullSector)) begin
      sector_c = SECT_GREEN_FALL;
      base_c   = HueW'(FullSector);
    end else begin
      sector_c = SECT_RED_RISE;
      base_c   = '0;
    end
  end

  // Offset inside the sector; a clamped hue sits at the far end of the last sector.
  always_comb begin
    if (hue_i >= HueW'(HueMax)) begin
      offset_c = WghtW'(FullSector);
    end else begin
      offset_c = WghtW'(hue_i - base_c);
    end
  end

  // The weight is 60 - k: the ramp channel gets the offset directly in falling sectors.
  assign ramp_c = sector_c[0] ? offset_c : WghtW'(WghtW'(FullSector) - offset_c);

  // Leading channel has weight zero, absent channel the full sector.
  always_comb begin
    unique case (sector_c)
      SECT_RED_RISE: begin
        w_red_d = '0; w_green_d = ramp_c; w_blue_d = WghtW'(FullSector);
      end
      SECT_GREEN_FALL: begin
        w_red_d = ramp_c; w_green_d = '0; w_blue_d = WghtW'(FullSector);
      end
      SECT_GREEN_RISE: begin
        w_red_d = WghtW'(FullSector); w_green_d = '0; w_blue_d = ramp_c;
      end
      SECT_BLUE_FALL: begin
        w_red_d = WghtW'(FullSector); w_green_d = ramp_c; w_blue_d = '0;
      end
      SECT_BLUE_RISE: begin
        w_red_d = ramp_c; w_green_d = WghtW'(FullSector); w_blue_d = '0;
      end
      default: begin
        w_red_d = '0; w_green_d = WghtW'(FullSector); w_blue_d = ramp_c;
      end
    endcase
  end

  // Chroma scale shared by all three channels.
  assign vs_d = VsW'(brightness_i) * VsW'(saturation_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      vs_q      <= vs_d;
      w_red_q   <= w_red_d;
      w_green_q <= w_green_d;
      w_blue_q  <= w_blue_d;
      bright_q  <= brightness_i;
    end
  end

  assign vs_o      = vs_q;
  assign w_red_o   = w_red_q;
  assign w_green_o = w_green_q;
  assign w_blue_o  = w_blue_q;
  assign bright_o  = bright_q;

endmodule

[rtl/core/hsv2rgb_chan.sv]
module hsv2rgb_chan
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  pipe_ctl_t        ctl_i,
  input  logic [VsW-1:0]   vs_i,
  input  logic [WghtW-1:0] w_i,
  input  logic [ChanW-1:0] bright_i,
  output logic [ChanW-1:0] level_o
);

  logic [ProdW-1:0]        prod_d, prod_q;
  logic [ChanW-1:0]        v2_q, v3_q;
  logic [ProdW-1:0]        num_d, num_q;
  logic [ProdW+RecipW-1:0] recip_c;
  logic [QuotW-1:0]        quot_d, quot_q;
  logic [ProdW-1:0]        back_c;
  logic [ProdW-1:0]        rem_c;
  logic [QuotW-1:0]        ceil_c;
  logic [ChanW-1:0]        level_d, level_q;

  // Stage two: weighted chroma product.
  assign prod_d = ProdW'(vs_i) * ProdW'(w_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      prod_q <= prod_d;
      v2_q   <= bright_i;
    end
  end

  // Stage three: bias for a ceiling and estimate the quotient by the reciprocal.
  // The estimate is the true quotient or one below it.
  assign num_d   = prod_q + ProdW'(ScaleDen - 1);
  assign recip_c = (ProdW+RecipW)'(num_d) * (ProdW+RecipW)'(RecipM);
  assign quot_d  = recip_c[ProdW+RecipW-1:RecipShift];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      num_q  <= num_d;
      quot_q <= quot_d;
      v3_q   <= v2_q;
    end
  end

  // Stage four: correct the estimate by one remainder compare and subtract the drop.
  assign back_c  = ProdW'(quot_q) * ProdW'(ScaleDen);
  assign rem_c   = num_q - back_c;
  assign ceil_c  = (rem_c >= ProdW'(ScaleDen)) ? QuotW'(quot_q + QuotW'(1)) : quot_q;
  assign level_d = v3_q - ceil_c[ChanW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

[rtl/core/hsv2rgb_checker.sv]
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ChanW-1:0] red_o,
  input logic [ChanW-1:0] green_o,
  input logic [ChanW-1:0] blue_o
);

  // A held output beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A held output beat keeps its colors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output colors changed while stalled");

  // The input side is only held back when the receiver holds the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with a free output");

  // An accepted beat reaches the output when the receiver does not stall while it passes the stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted beat did not arrive after four cycles");

endmodule

bind hsv_to_rgb_color_converter_core hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

[tb/hsv_rgb_scoreboard.sv]
// Color scoreboard for the HSV to RGB converter.
// It watches both channels, predicts the color of every accepted input beat
// and compares each result beat with the oldest prediction still waiting.
module hsv_rgb_scoreboard
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output int               err_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  rgb_t expected_rgb[$];
  rgb_t want_rgb;
  int   fail_total;

  // One channel level: brightness minus the exact ceiling of the chroma drop.
  function automatic logic [ChanW-1:0] lit_level(input logic [ChanW-1:0] v,
                                                 input logic [ChanW-1:0] s,
                                                 input int unsigned k);
    int unsigned prod;
    int unsigned drop;
    prod = int'(v) * int'(s) * (FullSector - k);
    drop = (prod + ScaleDen - 1) / ScaleDen;
    return ChanW'(int'(v) - drop);
  endfunction

  // Sector decode and channel weights for one hue sample.
  function automatic rgb_t predict_rgb(input logic [HueW-1:0] hue,
                                       input logic [ChanW-1:0] sat,
                                       input logic [ChanW-1:0] bri);
    sector_e     sect;
    int unsigned offs;
    int unsigned ramp;
    int unsigned k_red;
    int unsigned k_green;
    int unsigned k_blue;
    rgb_t        color;
    // Hues of 360 and above sit at the far end of the last sector.
    if (hue >= HueMax) begin
      sect = SECT_RED_FALL;
      offs = FullSector;
    end else begin
      sect = sector_e'(hue / FullSector);
      offs = hue % FullSector;
    end
    // The ramp rises in even sectors and falls in odd ones.
    ramp = sect[0] ? FullSector - offs : offs;
    case (sect)
      SECT_RED_RISE: begin
        k_red = FullSector; k_green = ramp; k_blue = 0;
      end
      SECT_GREEN_FALL: begin
        k_red = ramp; k_green = FullSector; k_blue = 0;
      end
      SECT_GREEN_RISE: begin
        k_red = 0; k_green = FullSector; k_blue = ramp;
      end
      SECT_BLUE_FALL: begin
        k_red = 0; k_green = ramp; k_blue = FullSector;
      end
      SECT_BLUE_RISE: begin
        k_red = ramp; k_green = 0; k_blue = FullSector;
      end
      default: begin
        k_red = FullSector; k_green = 0; k_blue = ramp;
      end
    endcase
    color.red   = lit_level(bri, sat, k_red);
    color.green = lit_level(bri, sat, k_green);
    color.blue  = lit_level(bri, sat, k_blue);
    return color;
  endfunction

  // Result beats are checked before the input beat of the same edge is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rgb.delete();
      fail_total = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rgb.size() == 0) begin
          $error("color beat with nothing expected: red %0d green %0d blue %0d",
                 red_i, green_i, blue_i);
          fail_total++;
        end else begin
          want_rgb = expected_rgb.pop_front();
          if (red_i !== want_rgb.red) begin
            $error("red: expected %0d, got %0d", want_rgb.red, red_i);
            fail_total++;
          end
          if (green_i !== want_rgb.green) begin
            $error("green: expected %0d, got %0d", want_rgb.green, green_i);
            fail_total++;
          end
          if (blue_i !== want_rgb.blue) begin
            $error("blue: expected %0d, got %0d", want_rgb.blue, blue_i);
            fail_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rgb.push_back(predict_rgb(hue_i, saturation_i, brightness_i));
      end
      err_count_o <= fail_total;
      pending_o   <= expected_rgb.size();
    end
  end

endmodule

[tb/tb.sv]
// Stimulus and verdict for the HSV to RGB converter.
module tb;
  import hsv2rgb_pkg::*;

  localparam int RandomBeats = 1700;
  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 150;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] brightness;
  logic             out_valid;
  logic             out_stall;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  int               err_count;
  int               pending;
  int               idle_cycles;
  logic             quiet;

  hsv_to_rgb_color_converter_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  hsv_rgb_scoreboard u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  // Clock with a period of 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Saturation and brightness lean toward the ends of the range.
  function automatic logic [ChanW-1:0] pick_level();
    logic [ChanW-1:0] ends[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return ends[$urandom_range(0, 3)];
    return ChanW'($urandom_range(0, 255));
  endfunction

  // Offer one beat and return at the edge that takes it.
  task automatic send_color(input logic [HueW-1:0] h, input logic [ChanW-1:0] s,
                            input logic [ChanW-1:0] v);
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_input(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the input off until every predicted color has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver side: stall bursts, one long hold-off, and clean stretches.
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    for (int burst = 0; ; burst++) begin
      int unsigned n;
      if (burst == 60) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(40, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sender side: directed corners, then random colors, then the verdict.
  initial begin
    logic [HueW-1:0] h;
    in_valid    <= 1'b0;
    hue         <= '0;
    saturation  <= '0;
    brightness  <= '0;
    quiet        = 1'b0;
    rst_n        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sector edges, hue 360 and above, and zero saturation or brightness.
    send_color(9'd0,   8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd59,  8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd60,  8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd119, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd120, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd179, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd180, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd239, 8'd200, 8'd255); pause_input(pick_gap());
    send_color(9'd240, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd299, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd300, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd359, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd360, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd361, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd511, 8'd255, 8'd255); pause_input(pick_gap());
    send_color(9'd30,  8'd0,   8'd255); pause_input(pick_gap());
    send_color(9'd90,  8'd0,   8'd0);   pause_input(pick_gap());
    send_color(9'd200, 8'd255, 8'd0);   pause_input(pick_gap());
    send_color(9'd45,  8'd0,   8'd128); pause_input(pick_gap());
    send_color(9'd330, 8'd1,   8'd1);   pause_input(pick_gap());
    send_color(9'd150, 8'd128, 8'd200); pause_input(pick_gap());
    send_color(9'd270, 8'd255, 8'd1);   pause_input(pick_gap());
    send_color(9'd15,  8'd1,   8'd255);
    wait_drained();

    // Random colors; blocks of 64 beats sometimes run with no gaps at all.
    for (int i = 0; i < RandomBeats; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RandomBeats / 2) wait_drained();
      if ($urandom_range(0, 99) < 85) h = HueW'($urandom_range(0, HueMax));
      else h = HueW'($urandom_range(0, 511));
      send_color(h, pick_level(), pick_level());
      if (!quiet) pause_input(pick_gap());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
